@@ rtl/core/mi_pkg.sv @@
`default_nettype none
package mi_pkg;

    localparam int ELEM_WIDTH = 24;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_ELEM   = 9;
    localparam int NUM_PROD   = 18;
    localparam int NUM_COL0   = 3;

    // element order: a d g b e h c f i (slots 0 1 2 4 5 6 8 9 10)
    // adjugate term k = prod(2k) - prod(2k+1)
    localparam int OP_A [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2,
                                       2, 0, 3, 4, 1, 0, 0, 1};
    localparam int OP_B [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6,
                                       3, 5, 7, 6, 6, 7, 4, 3};

    // determinant uses adjugate terms 0, 3 and 6 against a, d, g
    localparam int DET_ADJ [NUM_COL0] = '{0, 3, 6};

    function automatic int max_int(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mi_mat_if.sv @@
`default_nettype none
interface mi_mat_if #(
    parameter int W = mi_pkg::ELEM_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] m0;
    logic signed [W-1:0] m1;
    logic signed [W-1:0] m2;
    logic signed [W-1:0] m4;
    logic signed [W-1:0] m5;
    logic signed [W-1:0] m6;
    logic signed [W-1:0] m8;
    logic signed [W-1:0] m9;
    logic signed [W-1:0] m10;

    modport source (output valid, m0, m1, m2, m4, m5, m6, m8, m9, m10, input ready);
    modport sink   (input valid, m0, m1, m2, m4, m5, m6, m8, m9, m10, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mi_inv_if.sv @@
`default_nettype none
interface mi_inv_if #(
    parameter int W = mi_pkg::ELEM_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r0;
    logic signed [W-1:0] r1;
    logic signed [W-1:0] r2;
    logic signed [W-1:0] r4;
    logic signed [W-1:0] r5;
    logic signed [W-1:0] r6;
    logic signed [W-1:0] r8;
    logic signed [W-1:0] r9;
    logic signed [W-1:0] r10;
    logic                singular;
    logic                clipped;

    modport source (output valid, r0, r1, r2, r4, r5, r6, r8, r9, r10, singular, clipped,
                    input ready);
    modport sink   (input valid, r0, r1, r2, r4, r5, r6, r8, r9, r10, singular, clipped,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/mi_adj.sv @@
`default_nettype none
module mi_adj #(
    parameter int W = mi_pkg::ELEM_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic [1:0]            ld,
    input  wire logic signed [W-1:0]   m    [mi_pkg::NUM_ELEM],
    output logic signed [2*W:0]        adj  [mi_pkg::NUM_ELEM],
    output logic signed [W-1:0]        col0 [mi_pkg::NUM_COL0]
);

    localparam int AW = 2 * W + 1;
    localparam int MW = 2 * W;

    logic signed [2*W-1:0] prod_reg  [mi_pkg::NUM_PROD];
    logic signed [W-1:0]   col0a_reg [mi_pkg::NUM_COL0];
    logic signed [AW-1:0]  adj_reg   [mi_pkg::NUM_ELEM];
    logic signed [W-1:0]   col0b_reg [mi_pkg::NUM_COL0];

    // partial products
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int j = 0; j < mi_pkg::NUM_PROD; j++)
            begin
                prod_reg[j] <= MW'(m[mi_pkg::OP_A[j]]) * MW'(m[mi_pkg::OP_B[j]]);
            end
            for (int j = 0; j < mi_pkg::NUM_COL0; j++)
            begin
                col0a_reg[j] <= m[j];
            end
        end
    end

    // cofactor differences
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
            begin
                adj_reg[k] <= AW'(prod_reg[2*k]) - AW'(prod_reg[2*k+1]);
            end
            for (int j = 0; j < mi_pkg::NUM_COL0; j++)
            begin
                col0b_reg[j] <= col0a_reg[j];
            end
        end
    end

    assign adj  = adj_reg;
    assign col0 = col0b_reg;

endmodule
`default_nettype wire

@@ rtl/core/mi_det.sv @@
`default_nettype none
module mi_det #(
    parameter int W = mi_pkg::ELEM_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic [1:0]            ld,
    input  wire logic signed [2*W:0]   adj_in  [mi_pkg::NUM_ELEM],
    input  wire logic signed [W-1:0]   col0    [mi_pkg::NUM_COL0],
    output logic signed [2*W:0]        adj_out [mi_pkg::NUM_ELEM],
    output logic signed [3*W+2:0]      det
);

    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    logic signed [AW-1:0] ph_reg   [mi_pkg::NUM_COL0];
    logic signed [AW-1:0] pl_reg   [mi_pkg::NUM_COL0];
    logic signed [AW-1:0] adja_reg [mi_pkg::NUM_ELEM];
    logic signed [AW-1:0] adjb_reg [mi_pkg::NUM_ELEM];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    // adjugate split into signed high and unsigned low halves
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int j = 0; j < mi_pkg::NUM_COL0; j++)
            begin
                ph_reg[j] <= AW'(col0[j])
                           * AW'($signed(adj_in[mi_pkg::DET_ADJ[j]][AW-1:W]));
                pl_reg[j] <= AW'(col0[j])
                           * AW'($signed({1'b0, adj_in[mi_pkg::DET_ADJ[j]][W-1:0]}));
            end
            adja_reg <= adj_in;
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < mi_pkg::NUM_COL0; j++)
        begin
            det_next = det_next + (DW'(ph_reg[j]) <<< W) + DW'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            det_reg  <= det_next;
            adjb_reg <= adja_reg;
        end
    end

    assign adj_out = adjb_reg;
    assign det     = det_reg;

endmodule
`default_nettype wire

@@ rtl/core/mi_prep.sv @@
`default_nettype none
module mi_prep #(
    parameter int W = mi_pkg::ELEM_WIDTH,
    parameter int F = mi_pkg::FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic [1:0]            ld,
    input  wire logic signed [2*W:0]   adj [mi_pkg::NUM_ELEM],
    input  wire logic signed [3*W+2:0] det,
    output logic [3*W+3:0]             rem [mi_pkg::NUM_ELEM],
    output logic [W-1:0]               nlo [mi_pkg::NUM_ELEM],
    output logic [3*W+3:0]             dvs,
    output logic [mi_pkg::NUM_ELEM-1:0] neg,
    output logic [mi_pkg::NUM_ELEM-1:0] ovf,
    output logic                       zero
);

    localparam int AW  = 2 * W + 1;
    localparam int MW  = 2 * W;
    localparam int DW  = 3 * W + 3;
    localparam int D2W = DW + 1;
    localparam int NW  = mi_pkg::max_int(MW + 2 * F + 1, DW) + 1;
    localparam int TW  = NW - W;
    localparam int CW  = mi_pkg::max_int(TW, D2W);

    logic [DW-1:0]   dmag_reg;
    logic [MW-1:0]   amag_reg [mi_pkg::NUM_ELEM];
    logic [mi_pkg::NUM_ELEM-1:0] neg_a_reg;
    logic            zero_a_reg;
    logic [AW-1:0]   aabs [mi_pkg::NUM_ELEM];

    logic [D2W-1:0]  rem_reg [mi_pkg::NUM_ELEM];
    logic [W-1:0]    nlo_reg [mi_pkg::NUM_ELEM];
    logic [D2W-1:0]  dvs_reg;
    logic [mi_pkg::NUM_ELEM-1:0] neg_b_reg;
    logic [mi_pkg::NUM_ELEM-1:0] ovf_reg;
    logic            zero_b_reg;

    logic [NW-1:0]   num  [mi_pkg::NUM_ELEM];
    logic [CW-1:0]   top  [mi_pkg::NUM_ELEM];
    logic [D2W-1:0]  dvs_next;

    always_comb
    begin
        for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
        begin
            aabs[k] = adj[k][AW-1] ? (~adj[k] + 1'b1) : adj[k];
        end
    end

    // magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            dmag_reg <= det[DW-1] ? (~det + 1'b1) : det;
            for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
            begin
                amag_reg[k]  <= aabs[k][MW-1:0];
                neg_a_reg[k] <= adj[k][AW-1] ^ det[DW-1];
            end
            zero_a_reg <= (det == '0);
        end
    end

    // numerator 2*|adj|*2^(2F) + |det| over divisor 2*|det|, rounds to nearest
    always_comb
    begin
        dvs_next = {dmag_reg, 1'b0};
        for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
        begin
            num[k] = (NW'(amag_reg[k]) << (2 * F + 1)) + NW'(dmag_reg);
            top[k] = CW'(num[k][NW-1:W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
            begin
                rem_reg[k] <= top[k][D2W-1:0];
                nlo_reg[k] <= num[k][W-1:0];
                ovf_reg[k] <= (top[k] >= CW'(dvs_next));
            end
            dvs_reg    <= dvs_next;
            neg_b_reg  <= neg_a_reg;
            zero_b_reg <= zero_a_reg;
        end
    end

    assign rem  = rem_reg;
    assign nlo  = nlo_reg;
    assign dvs  = dvs_reg;
    assign neg  = neg_b_reg;
    assign ovf  = ovf_reg;
    assign zero = zero_b_reg;

endmodule
`default_nettype wire

@@ rtl/core/mi_div.sv @@
`default_nettype none
module mi_div #(
    parameter int W = mi_pkg::ELEM_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic [W-1:0]                ld,
    input  wire logic [3*W+3:0]              rem_in [mi_pkg::NUM_ELEM],
    input  wire logic [W-1:0]                nlo_in [mi_pkg::NUM_ELEM],
    input  wire logic [3*W+3:0]              dvs_in,
    input  wire logic [mi_pkg::NUM_ELEM-1:0] neg_in,
    input  wire logic [mi_pkg::NUM_ELEM-1:0] ovf_in,
    input  wire logic                        zero_in,
    output logic [W-1:0]                     quo    [mi_pkg::NUM_ELEM],
    output logic [mi_pkg::NUM_ELEM-1:0]      neg,
    output logic [mi_pkg::NUM_ELEM-1:0]      ovf,
    output logic                             zero
);

    localparam int D2W = 3 * W + 4;

    // one quotient bit per stage, all nine lanes share the divisor
    logic [D2W-1:0] rem_reg  [W][mi_pkg::NUM_ELEM];
    logic [W-1:0]   nlo_reg  [W][mi_pkg::NUM_ELEM];
    logic [W-1:0]   quo_reg  [W][mi_pkg::NUM_ELEM];
    logic [D2W-1:0] dvs_reg  [W];
    logic [mi_pkg::NUM_ELEM-1:0] neg_reg [W];
    logic [mi_pkg::NUM_ELEM-1:0] ovf_reg [W];
    logic [W-1:0]   zero_reg;

    logic [D2W-1:0] rem_next [W][mi_pkg::NUM_ELEM];
    logic [W-1:0]   nlo_next [W][mi_pkg::NUM_ELEM];
    logic [W-1:0]   quo_next [W][mi_pkg::NUM_ELEM];
    logic [D2W-1:0] dvs_src  [W];
    logic [mi_pkg::NUM_ELEM-1:0] neg_src [W];
    logic [mi_pkg::NUM_ELEM-1:0] ovf_src [W];
    logic [W-1:0]   zero_src;

    always_comb
    begin
        logic [D2W-1:0] r_src;
        logic [W-1:0]   n_src;
        logic [W-1:0]   q_src;
        logic [D2W:0]   trial;
        logic           ge;
        for (int s = 0; s < W; s++)
        begin
            if (s == 0)
            begin
                dvs_src[s]  = dvs_in;
                neg_src[s]  = neg_in;
                ovf_src[s]  = ovf_in;
                zero_src[s] = zero_in;
            end
            else
            begin
                dvs_src[s]  = dvs_reg[s-1];
                neg_src[s]  = neg_reg[s-1];
                ovf_src[s]  = ovf_reg[s-1];
                zero_src[s] = zero_reg[s-1];
            end
            for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
            begin
                if (s == 0)
                begin
                    r_src = rem_in[k];
                    n_src = nlo_in[k];
                    q_src = '0;
                end
                else
                begin
                    r_src = rem_reg[s-1][k];
                    n_src = nlo_reg[s-1][k];
                    q_src = quo_reg[s-1][k];
                end
                trial = {r_src, n_src[W-1]};
                ge    = (trial >= {1'b0, dvs_src[s]});
                rem_next[s][k] = ge ? D2W'(trial - {1'b0, dvs_src[s]}) : trial[D2W-1:0];
                nlo_next[s][k] = n_src << 1;
                quo_next[s][k] = {q_src[W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < W; s++)
        begin
            if (ld[s])
            begin
                rem_reg[s]  <= rem_next[s];
                nlo_reg[s]  <= nlo_next[s];
                quo_reg[s]  <= quo_next[s];
                dvs_reg[s]  <= dvs_src[s];
                neg_reg[s]  <= neg_src[s];
                ovf_reg[s]  <= ovf_src[s];
                zero_reg[s] <= zero_src[s];
            end
        end
    end

    assign quo  = quo_reg[W-1];
    assign neg  = neg_reg[W-1];
    assign ovf  = ovf_reg[W-1];
    assign zero = zero_reg[W-1];

endmodule
`default_nettype wire

@@ rtl/core/mi_fmt.sv @@
`default_nettype none
module mi_fmt #(
    parameter int W = mi_pkg::ELEM_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        ld,
    input  wire logic [W-1:0]                quo [mi_pkg::NUM_ELEM],
    input  wire logic [mi_pkg::NUM_ELEM-1:0] neg,
    input  wire logic [mi_pkg::NUM_ELEM-1:0] ovf,
    input  wire logic                        zero,
    output logic signed [W-1:0]              res [mi_pkg::NUM_ELEM],
    output logic                             singular,
    output logic                             clipped
);

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] res_reg [mi_pkg::NUM_ELEM];
    logic                singular_reg;
    logic                clipped_reg;

    logic signed [W-1:0] res_next [mi_pkg::NUM_ELEM];
    logic                clipped_next;

    // saturate, then restore the sign, or zero the result when singular
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        logic         clip;
        clipped_next = 1'b0;
        for (int k = 0; k < mi_pkg::NUM_ELEM; k++)
        begin
            lim  = neg[k] ? LIM_NEG : LIM_POS;
            clip = ovf[k] | (quo[k] > lim);
            mag  = clip ? lim : quo[k];
            res_next[k] = zero ? '0 : $signed(neg[k] ? (~mag + 1'b1) : mag);
            clipped_next = clipped_next | (clip & ~zero);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg      <= res_next;
            singular_reg <= zero;
            clipped_reg  <= clipped_next;
        end
    end

    assign res      = res_reg;
    assign singular = singular_reg;
    assign clipped  = clipped_reg;

endmodule
`default_nettype wire

@@ rtl/core/matrix3_inverse_top.sv @@
// channel  dir  payload                                    transfer
// mat      in   m0 m1 m2 m4 m5 m6 m8 m9 m10                valid & ready
// inv      out  r0 r1 r2 r4 r5 r6 r8 r9 r10 singular clipped valid & ready
//
// one matrix per cycle while inv is ready
// the divider is restoring, one quotient bit per stage
// rst_n clears only the stage valid bits, data registers are not reset
// a stall holds only the full stages in front of it, empty stages keep filling
`default_nettype none
module matrix3_inverse_top #(
    parameter int FRAC_BITS  = mi_pkg::FRAC_BITS,
    parameter int ELEM_WIDTH = mi_pkg::ELEM_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mi_mat_if.sink    mat,
    mi_inv_if.source  inv
);

    localparam int W   = ELEM_WIDTH;
    localparam int NST = W + 7;
    localparam int DIV0 = 6;

    logic [NST-1:0] v_reg;
    logic [NST:0]   adv;

    logic signed [W-1:0]   elem [mi_pkg::NUM_ELEM];
    logic signed [2*W:0]   adj1 [mi_pkg::NUM_ELEM];
    logic signed [W-1:0]   col0 [mi_pkg::NUM_COL0];
    logic signed [2*W:0]   adj3 [mi_pkg::NUM_ELEM];
    logic signed [3*W+2:0] det;
    logic [3*W+3:0]        rem  [mi_pkg::NUM_ELEM];
    logic [W-1:0]          nlo  [mi_pkg::NUM_ELEM];
    logic [3*W+3:0]        dvs;
    logic [mi_pkg::NUM_ELEM-1:0] neg_p;
    logic [mi_pkg::NUM_ELEM-1:0] ovf_p;
    logic                  zero_p;
    logic [W-1:0]          quo  [mi_pkg::NUM_ELEM];
    logic [mi_pkg::NUM_ELEM-1:0] neg_d;
    logic [mi_pkg::NUM_ELEM-1:0] ovf_d;
    logic                  zero_d;
    logic signed [W-1:0]   res  [mi_pkg::NUM_ELEM];

    assign elem = '{mat.m0, mat.m1, mat.m2, mat.m4, mat.m5, mat.m6, mat.m8, mat.m9, mat.m10};

    // a stage advances when empty or when the next one advances
    always_comb
    begin
        adv[NST] = inv.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            adv[k] = ~v_reg[k] | adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= (k == 0) ? mat.valid : v_reg[k-1];
                end
            end
        end
    end

    assign mat.ready = adv[0];
    assign inv.valid = v_reg[NST-1];

    mi_adj #(.W(W)) u_adj (
        .clk  (clk),
        .ld   (adv[1:0]),
        .m    (elem),
        .adj  (adj1),
        .col0 (col0)
    );

    mi_det #(.W(W)) u_det (
        .clk     (clk),
        .ld      (adv[3:2]),
        .adj_in  (adj1),
        .col0    (col0),
        .adj_out (adj3),
        .det     (det)
    );

    mi_prep #(.W(W), .F(FRAC_BITS)) u_prep (
        .clk  (clk),
        .ld   (adv[5:4]),
        .adj  (adj3),
        .det  (det),
        .rem  (rem),
        .nlo  (nlo),
        .dvs  (dvs),
        .neg  (neg_p),
        .ovf  (ovf_p),
        .zero (zero_p)
    );

    mi_div #(.W(W)) u_div (
        .clk     (clk),
        .ld      (adv[DIV0+W-1:DIV0]),
        .rem_in  (rem),
        .nlo_in  (nlo),
        .dvs_in  (dvs),
        .neg_in  (neg_p),
        .ovf_in  (ovf_p),
        .zero_in (zero_p),
        .quo     (quo),
        .neg     (neg_d),
        .ovf     (ovf_d),
        .zero    (zero_d)
    );

    mi_fmt #(.W(W)) u_fmt (
        .clk      (clk),
        .ld       (adv[NST-1]),
        .quo      (quo),
        .neg      (neg_d),
        .ovf      (ovf_d),
        .zero     (zero_d),
        .res      (res),
        .singular (inv.singular),
        .clipped  (inv.clipped)
    );

    assign inv.r0  = res[0];
    assign inv.r1  = res[1];
    assign inv.r2  = res[2];
    assign inv.r4  = res[3];
    assign inv.r5  = res[4];
    assign inv.r6  = res[5];
    assign inv.r8  = res[6];
    assign inv.r9  = res[7];
    assign inv.r10 = res[8];

    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (inv.valid && inv.singular) |-> (!inv.clipped && inv.r0 == '0 && inv.r5 == '0))
        else $error("singular result not cleared");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !mat.ready |-> (&v_reg))
        else $error("input stalled with an empty stage");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (mat.valid && mat.ready && !(inv.valid && inv.ready))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("pipeline occupancy lost an item");

endmodule
`default_nettype wire

@@ bench/tb_inverse_checker.sv @@
`default_nettype none
module tb_inverse_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    mi_mat_if         mat,
    mi_inv_if         inv,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = mi_pkg::ELEM_WIDTH;
    localparam int FB = mi_pkg::FRAC_BITS;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [EW-1:0] elem [9];
        logic          singular;
        logic          clipped;
    } inverse_t;

    inverse_t expected_inverses [$];
    int       transfer_no = 0;

    initial fail_count = 0;
    initial pending = 0;

    task automatic report(input string what, input logic [EW-1:0] got,
                          input logic [EW-1:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", transfer_no, what, got, want);
        fail_count++;
    endtask

    function automatic logic [EW-1:0] rounded_quotient(input wide_t adj, input wide_t det,
                                                      inout logic clip);
        logic          neg;
        logic [191:0]  n;
        logic [191:0]  d;
        logic [191:0]  q;
        logic [191:0]  lim;
        neg = adj[191] ^ det[191];
        n   = adj[191] ? -adj : adj;
        d   = det[191] ? -det : det;
        q   = ((n << (2 * FB + 1)) + d) / (d << 1);
        lim = neg ? (192'd1 << (EW - 1)) : ((192'd1 << (EW - 1)) - 1);
        if (q > lim)
        begin
            q    = lim;
            clip = 1'b1;
        end
        return neg ? (-q[EW-1:0]) : q[EW-1:0];
    endfunction

    function automatic inverse_t invert3(input logic signed [EW-1:0] m [9]);
        inverse_t res;
        wide_t    a, d, g, b, e, h, c, f, i;
        wide_t    adj [9];
        wide_t    det;
        logic     clip;
        a = wide_t'(m[0]); d = wide_t'(m[1]); g = wide_t'(m[2]);
        b = wide_t'(m[3]); e = wide_t'(m[4]); h = wide_t'(m[5]);
        c = wide_t'(m[6]); f = wide_t'(m[7]); i = wide_t'(m[8]);
        adj[0] = e * i - h * f;
        adj[1] = g * f - d * i;
        adj[2] = d * h - g * e;
        adj[3] = h * c - b * i;
        adj[4] = a * i - g * c;
        adj[5] = g * b - a * h;
        adj[6] = b * f - e * c;
        adj[7] = d * c - a * f;
        adj[8] = a * e - d * b;
        det = a * adj[0] + d * adj[3] + g * adj[6];
        clip = 1'b0;
        res.singular = (det == 0);
        for (int k = 0; k < 9; k++)
            res.elem[k] = res.singular ? '0 : rounded_quotient(adj[k], det, clip);
        res.clipped = clip;
        return res;
    endfunction

    always @(posedge clk)
    begin
        logic signed [EW-1:0] m [9];
        logic [EW-1:0]        got [9];
        inverse_t             want;
        if (rst_n && mat.valid && mat.ready)
        begin
            m = '{mat.m0, mat.m1, mat.m2, mat.m4, mat.m5, mat.m6, mat.m8, mat.m9, mat.m10};
            expected_inverses.push_back(invert3(m));
        end
        if (rst_n && inv.valid && inv.ready)
        begin
            transfer_no++;
            if (expected_inverses.size() == 0)
            begin
                $display("unexpected result %0d", transfer_no);
                fail_count++;
            end
            else
            begin
                want = expected_inverses.pop_front();
                got  = '{inv.r0, inv.r1, inv.r2, inv.r4, inv.r5, inv.r6, inv.r8, inv.r9,
                         inv.r10};
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.elem[k])
                        report($sformatf("r[%0d]", k), got[k], want.elem[k]);
                if (inv.singular !== want.singular)
                    report("singular", EW'(inv.singular), EW'(want.singular));
                if (inv.clipped !== want.clipped)
                    report("clipped", EW'(inv.clipped), EW'(want.clipped));
            end
        end
        pending = expected_inverses.size();
    end
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW    = mi_pkg::ELEM_WIDTH;
    localparam int ONE   = 1 << mi_pkg::FRAC_BITS;
    localparam int DRAIN = EW + 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_pct = 0;
    int   stall_pct = 0;

    mi_mat_if mat ();
    mi_inv_if inv ();

    matrix3_inverse_top dut (.clk(clk), .rst_n(rst_n), .mat(mat), .inv(inv));

    tb_inverse_checker checker_i (
        .clk(clk), .rst_n(rst_n), .mat(mat), .inv(inv),
        .fail_count(fail_count), .pending(pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        inv.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            inv.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_matrix(input int v [9]);
        while ($urandom_range(99) < idle_pct)
        begin
            mat.valid <= 1'b0;
            @(posedge clk);
        end
        mat.valid <= 1'b1;
        mat.m0 <= EW'(v[0]); mat.m1 <= EW'(v[1]); mat.m2  <= EW'(v[2]);
        mat.m4 <= EW'(v[3]); mat.m5 <= EW'(v[4]); mat.m6  <= EW'(v[5]);
        mat.m8 <= EW'(v[6]); mat.m9 <= EW'(v[7]); mat.m10 <= EW'(v[8]);
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        mat.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [EW-1:0] rand_elem();
        return EW'($urandom());
    endfunction

    function automatic void random_matrix(output int v [9]);
        int mode;
        int sh;
        mode = $urandom_range(9);
        for (int k = 0; k < 9; k++)
        begin
            sh = $urandom_range(EW - 1);
            case (mode)
                0, 1, 2: v[k] = int'(rand_elem());
                3, 4, 5, 6:
                    v[k] = (k % 4 == 0)
                         ? ($urandom_range(1) ? 1 : -1)
                           * int'($urandom_range(ONE / 4, 4 * ONE))
                         : int'($urandom_range(ONE)) - ONE / 2;
                default: v[k] = int'(rand_elem() >>> sh);
            endcase
        end
        if (mode == 7)
            for (int k = 0; k < 3; k++)
                v[6 + k] = v[k];
        if (mode == 8)
        begin
            v[1] = 0; v[4] = 0; v[7] = 0;
        end
    endfunction

    initial
    begin
        int v [9];
        int mx;
        int mn;
        mx = (1 << (EW - 1)) - 1;
        mn = -(1 << (EW - 1));
        mat.valid = 1'b0;
        mat.m0 = '0; mat.m1 = '0; mat.m2  = '0;
        mat.m4 = '0; mat.m5 = '0; mat.m6  = '0;
        mat.m8 = '0; mat.m9 = '0; mat.m10 = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, zero, constant and diagonal matrices
        send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
        send_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
        send_matrix('{mx, 0, 0, 0, mn, 0, 0, 0, mx});
        send_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn});
        send_matrix('{-ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, -ONE / 2});
        // tiny diagonal saturates both ways
        send_matrix('{1, 0, 0, 0, -1, 0, 0, 0, 1});
        // rounding ties, away from zero
        send_matrix('{2 * ONE, 0, 0, 2, 2 * ONE, 0, 0, 0, ONE});
        send_matrix('{2 * ONE, 0, 0, -6, 2 * ONE, 0, 0, 0, ONE});
        send_matrix('{2 * ONE, 0, 0, 6, 2 * ONE, 0, 0, 0, -ONE});
        send_matrix('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                      10 * ONE});
        send_matrix('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
        send_matrix('{mx, mn, mx, mn, mx, mn, mx, mn, -1});
        send_matrix('{-1, -1, 0, 0, -1, -1, -1, 0, -1});
        // hold off until everything has drained
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (int n = 0; n < 210; n++)
            begin
                random_matrix(v);
                send_matrix(v);
            end
            if (phase == 1)
                wait_drained();
        end
        stall_pct = 0;
        wait_drained();
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/mi_pkg.sv
rtl/core/mi_mat_if.sv
rtl/core/mi_inv_if.sv
rtl/core/mi_adj.sv
rtl/core/mi_det.sv
rtl/core/mi_prep.sv
rtl/core/mi_div.sv
rtl/core/mi_fmt.sv
rtl/core/matrix3_inverse_top.sv
bench/tb_inverse_checker.sv
bench/tb_top.sv
